>>> src/tlvrl_pkg.sv
// Shared types and constants for the TLV record lookup block.
// Depends on nothing; every other file of the block imports it.
package tlvrl_pkg;

  localparam int DEF_MAX_BUFFER_BYTES = 4096;
  localparam int HDR_BYTES = 3;

  localparam int LEN_W = 13;
  localparam int REC_W = 16;
  localparam int CAP_W = 17;
  localparam int WORD_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 17'd256;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TYPE = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_LEN_LO = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;
  localparam logic [2:0] PH_WORD = 3'd5;
  localparam logic [2:0] PH_STRING = 3'd6;

  localparam logic [2:0] ST_WORD = 3'd0;
  localparam logic [2:0] ST_BYTE = 3'd1;
  localparam logic [2:0] ST_DONE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_MALFORMED = 3'd4;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd5;

  typedef struct packed {
    logic [2:0]        phase;
    logic [LEN_W-1:0]  pos;
    logic [LEN_W-1:0]  total;
    logic [7:0]        wanted;
    logic              smode;
    logic              matched;
    logic [REC_W-1:0]  rlen;
    logic [REC_W-1:0]  left;
    logic [WORD_W-1:0] acc;
  } scan_state_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        byte_value;
    logic [LEN_W-1:0]  buffer_length;
    logic [7:0]        search_type;
    logic              value_mode;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [WORD_W-1:0] value;
    logic              last;
  } result_t;

endpackage

>>> src/tlvrl_in_if.sv
// Request channel of the TLV record lookup block: valid/ready plus fields.
// Depends on tlvrl_pkg for field widths.
interface tlvrl_in_if;
  import tlvrl_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [7:0]       byte_value;
  logic [LEN_W-1:0] buffer_length;
  logic [7:0]       search_type;
  logic             value_mode;

  modport source (output valid, kind, byte_value, buffer_length, search_type, value_mode,
                  input ready);
  modport sink (input valid, kind, byte_value, buffer_length, search_type, value_mode,
                output ready);
endinterface

>>> src/tlvrl_out_if.sv
// Result channel of the TLV record lookup block: valid/ready plus fields.
// Depends on tlvrl_pkg for field widths.
interface tlvrl_out_if;
  import tlvrl_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [WORD_W-1:0] value;
  logic              last;

  modport source (output valid, status, value, last, input ready);
  modport sink (input valid, status, value, last, output ready);
endinterface

>>> src/tlv_record_lookup_core.sv
// Top level of the TLV record lookup block: state and result registers.
// Depends on tlvrl_pkg, tlvrl_in_if, tlvrl_out_if and tlvrl_step.
//
//   channel   direction  handshake            contents
//   in_chan   sink       valid/ready          start request or one buffer byte
//   out_chan  source     valid/ready          status, value, last
//   cfg       write      cfg_we               string_capacity (17 bits)
//
// One request is taken per cycle while in_chan.ready is high; its result, if any,
// appears in the output register on the following cycle. Each request passes through
// one level of counter and compare logic, which sets that rate. in_chan.ready is low
// only while a result waits and out_chan.ready is low. Reset is synchronous and
// returns the scanner to idle with a string capacity of 256.
module tlv_record_lookup_core #(
  parameter int MAX_BUFFER_BYTES = tlvrl_pkg::DEF_MAX_BUFFER_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tlvrl_in_if.sink                    in_chan,
  tlvrl_out_if.source                 out_chan,
  input  logic                        cfg_we,
  input  logic [tlvrl_pkg::CAP_W-1:0] cfg_wdata
);
  import tlvrl_pkg::*;

  scan_state_t      state_r;
  scan_state_t      state_nxt;
  logic [CAP_W-1:0] cap_r;
  req_t             req;
  logic             res_valid;
  result_t          res;
  logic             out_valid_r;
  result_t          out_r;
  logic             accept;

  assign req = '{kind:          in_chan.kind,
                 byte_value:    in_chan.byte_value,
                 buffer_length: in_chan.buffer_length,
                 search_type:   in_chan.search_type,
                 value_mode:    in_chan.value_mode};

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept = in_chan.valid && in_chan.ready;

  tlvrl_step #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_step (
    .st(state_r),
    .req(req),
    .cap(cap_r),
    .nxt(state_nxt),
    .res_valid(res_valid),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      cap_r <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (accept) begin
        state_r <= state_nxt;
        out_valid_r <= res_valid;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_r <= res;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.status = out_r.status;
  assign out_chan.value = out_r.value;
  assign out_chan.last = out_r.last;

endmodule

>>> src/tlvrl_step.sv
// Next-state and result logic for one request of the TLV record scanner.
// Depends on tlvrl_pkg for the state, request and result types.
module tlvrl_step #(
  parameter int MAX_BUFFER_BYTES = tlvrl_pkg::DEF_MAX_BUFFER_BYTES
) (
  input  tlvrl_pkg::scan_state_t             st,
  input  tlvrl_pkg::req_t                    req,
  input  logic [tlvrl_pkg::CAP_W-1:0]        cap,
  output tlvrl_pkg::scan_state_t             nxt,
  output logic                               res_valid,
  output tlvrl_pkg::result_t                 res
);
  import tlvrl_pkg::*;

  localparam logic [CAP_W-1:0] MAX_LEN = CAP_W'(MAX_BUFFER_BYTES);

  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] pos_inc;
  logic [LEN_W-1:0] bnd_pos;
  logic [LEN_W-1:0] bnd_total;
  logic             bnd_nf;
  logic             bnd_mal;
  logic [REC_W-1:0] rlen_new;
  logic [REC_W-1:0] left_dec;
  logic [WORD_W-1:0] acc_new;
  logic             overrun;
  logic             too_long;

  assign len_sat = ({4'b0, req.buffer_length} > MAX_LEN) ? MAX_LEN[LEN_W-1:0]
                                                           : req.buffer_length;
  assign pos_inc = st.pos + 1'b1;
  assign bnd_pos = req.kind ? pos_inc : '0;
  assign bnd_total = req.kind ? st.total : len_sat;
  assign bnd_nf = bnd_pos >= bnd_total;
  assign bnd_mal = ({1'b0, bnd_pos} + (LEN_W+1)'(HDR_BYTES)) > {1'b0, bnd_total};
  assign rlen_new = {st.rlen[15:8], req.byte_value};
  assign left_dec = st.left - 1'b1;
  assign acc_new = {st.acc[23:0], req.byte_value};
  assign overrun = ({4'b0, pos_inc} + {1'b0, rlen_new}) > {4'b0, st.total};
  assign too_long = ({1'b0, rlen_new} + 1'b1) > cap;

  always_comb begin
    nxt = st;
    res_valid = 1'b0;
    res = '0;
    if (!req.kind) begin
      nxt.total = len_sat;
      nxt.wanted = req.search_type;
      nxt.smode = req.value_mode;
      nxt.pos = '0;
      nxt.matched = 1'b0;
      nxt.rlen = '0;
      nxt.left = '0;
      nxt.acc = '0;
      nxt.phase = PH_TYPE;
      if (bnd_nf) begin
        res_valid = 1'b1;
        res.status = ST_NOT_FOUND;
      end else if (bnd_mal) begin
        res_valid = 1'b1;
        res.status = ST_MALFORMED;
      end
    end else if (st.phase != PH_IDLE) begin
      nxt.pos = pos_inc;
      case (st.phase)
        PH_TYPE: begin
          nxt.matched = (req.byte_value == st.wanted);
          nxt.phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          nxt.rlen = {req.byte_value, 8'h00};
          nxt.phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          nxt.rlen = rlen_new;
          if (overrun) begin
            res_valid = 1'b1;
            res.status = ST_MALFORMED;
          end else if (!st.matched) begin
            if (rlen_new == '0) begin
              nxt.phase = PH_TYPE;
              if (bnd_nf) begin
                res_valid = 1'b1;
                res.status = ST_NOT_FOUND;
              end else if (bnd_mal) begin
                res_valid = 1'b1;
                res.status = ST_MALFORMED;
              end
            end else begin
              nxt.left = rlen_new;
              nxt.phase = PH_SKIP;
            end
          end else if (!st.smode) begin
            if (rlen_new != REC_W'(4)) begin
              res_valid = 1'b1;
              res.status = ST_BAD_LENGTH;
            end else begin
              nxt.left = REC_W'(4);
              nxt.acc = '0;
              nxt.phase = PH_WORD;
            end
          end else if (too_long) begin
            res_valid = 1'b1;
            res.status = ST_BAD_LENGTH;
          end else if (rlen_new == '0) begin
            res_valid = 1'b1;
            res.status = ST_DONE;
          end else begin
            nxt.left = rlen_new;
            nxt.phase = PH_STRING;
          end
        end
        PH_SKIP: begin
          nxt.left = left_dec;
          if (left_dec == '0) begin
            nxt.phase = PH_TYPE;
            if (bnd_nf) begin
              res_valid = 1'b1;
              res.status = ST_NOT_FOUND;
            end else if (bnd_mal) begin
              res_valid = 1'b1;
              res.status = ST_MALFORMED;
            end
          end
        end
        PH_WORD: begin
          nxt.acc = acc_new;
          nxt.left = left_dec;
          if (left_dec == '0) begin
            res_valid = 1'b1;
            res.status = ST_WORD;
            res.value = acc_new;
          end
        end
        PH_STRING: begin
          nxt.left = left_dec;
          res_valid = 1'b1;
          res.status = ST_BYTE;
          res.value = {24'b0, req.byte_value};
        end
        default: begin
          nxt.phase = PH_IDLE;
        end
      endcase
    end
    // Every result ends the search except a string byte that is not the last one.
    res.last = res_valid && !(res.status == ST_BYTE && left_dec != '0);
    if (res.last) begin
      nxt.phase = PH_IDLE;
    end
  end

endmodule

>>> src/tlvrl_checker.sv
// Port-level checks on the result channel of the TLV record lookup block.
// Depends on tlvrl_pkg; bound to tlv_record_lookup_core at the end of this file.
module tlvrl_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [2:0]                   out_status,
  input logic [tlvrl_pkg::WORD_W-1:0] out_value,
  input logic                         out_last
);
  import tlvrl_pkg::*;

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_value) && $stable(out_last))
    else $error("result changed while stalled");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_WORD && out_status != ST_BYTE |-> out_value == '0)
    else $error("nonzero value on a status without data");

  a_byte_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BYTE |-> out_value[WORD_W-1:8] == '0)
    else $error("string byte wider than eight bits");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_BYTE |-> out_last)
    else $error("terminal status without last");

endmodule

bind tlv_record_lookup_core tlvrl_checker u_tlvrl_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_status(out_chan.status),
  .out_value(out_chan.value),
  .out_last(out_chan.last)
);

>>> sim/tlvrl_lookup_checker.sv
// Watches the request, result and configuration ports of the TLV record lookup block,
// predicts every result from its own copy of the scan state and compares in order.
// Depends on tlvrl_pkg and the two channel interfaces.
module tlvrl_lookup_checker
  import tlvrl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  tlvrl_in_if              in_chan,
  tlvrl_out_if             out_chan,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               open_count,
  output int               result_count
);

  localparam int MAX_BYTES = DEF_MAX_BUFFER_BYTES;

  logic [2:0]        scan_phase;
  logic [LEN_W-1:0]  scan_pos;
  logic [LEN_W-1:0]  scan_total;
  logic [7:0]        scan_type;
  logic              scan_string;
  logic              type_hit;
  logic [REC_W-1:0]  rec_len;
  logic [REC_W-1:0]  rec_left;
  logic [WORD_W-1:0] word_acc;
  logic [CAP_W-1:0]  str_cap;
  result_t           awaited_results[$];
  int                fails;
  int                results;

  function automatic void post_result(input logic [2:0] status, input logic [WORD_W-1:0] value,
                                      input logic fin);
    result_t r;
    r.status = status;
    r.value = value;
    r.last = fin;
    awaited_results.push_back(r);
    if (fin) scan_phase = PH_IDLE;
  endfunction

  // A record boundary decides the search at once when too few bytes remain.
  function automatic void reach_boundary();
    if (scan_pos >= scan_total) begin
      post_result(ST_NOT_FOUND, '0, 1'b1);
    end else if (int'(scan_pos) + HDR_BYTES > int'(scan_total)) begin
      post_result(ST_MALFORMED, '0, 1'b1);
    end else begin
      scan_phase = PH_TYPE;
    end
  endfunction

  function automatic void close_header();
    if (int'(scan_pos) + int'(rec_len) > int'(scan_total)) begin
      post_result(ST_MALFORMED, '0, 1'b1);
    end else if (!type_hit) begin
      if (rec_len == 0) begin
        reach_boundary();
      end else begin
        rec_left = rec_len;
        scan_phase = PH_SKIP;
      end
    end else if (!scan_string) begin
      if (rec_len != 4) begin
        post_result(ST_BAD_LENGTH, '0, 1'b1);
      end else begin
        rec_left = 4;
        word_acc = '0;
        scan_phase = PH_WORD;
      end
    end else if (int'(rec_len) + 1 > int'(str_cap)) begin
      post_result(ST_BAD_LENGTH, '0, 1'b1);
    end else if (rec_len == 0) begin
      post_result(ST_DONE, '0, 1'b1);
    end else begin
      rec_left = rec_len;
      scan_phase = PH_STRING;
    end
  endfunction

  function automatic void scan_request(input req_t rq);
    if (rq.kind == 1'b0) begin
      scan_total = (int'(rq.buffer_length) > MAX_BYTES) ? LEN_W'(MAX_BYTES) : rq.buffer_length;
      scan_type = rq.search_type;
      scan_string = rq.value_mode;
      scan_pos = '0;
      type_hit = 1'b0;
      rec_len = '0;
      rec_left = '0;
      word_acc = '0;
      reach_boundary();
    end else if (scan_phase != PH_IDLE) begin
      scan_pos = scan_pos + 1'b1;
      case (scan_phase)
        PH_TYPE: begin
          type_hit = (rq.byte_value == scan_type);
          scan_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          rec_len = {rq.byte_value, 8'h00};
          scan_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          rec_len[7:0] = rq.byte_value;
          close_header();
        end
        PH_SKIP: begin
          rec_left = rec_left - 1'b1;
          if (rec_left == 0) reach_boundary();
        end
        PH_WORD: begin
          word_acc = {word_acc[WORD_W-9:0], rq.byte_value};
          rec_left = rec_left - 1'b1;
          if (rec_left == 0) post_result(ST_WORD, word_acc, 1'b1);
        end
        PH_STRING: begin
          rec_left = rec_left - 1'b1;
          post_result(ST_BYTE, {24'h000000, rq.byte_value}, rec_left == 0);
        end
        default: begin
          scan_phase = PH_IDLE;
        end
      endcase
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    req_t    rq;
    if (!rst_n) begin
      scan_phase = PH_IDLE;
      scan_pos = '0;
      scan_total = '0;
      scan_type = '0;
      scan_string = 1'b0;
      type_hit = 1'b0;
      rec_len = '0;
      rec_left = '0;
      word_acc = '0;
      str_cap = CAP_RESET;
      awaited_results.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.status = out_chan.status;
        got.value = out_chan.value;
        got.last = out_chan.last;
        results++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d value=%h last=%b", $time, got.status,
                   got.value, got.last);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.value !== want.value ||
              got.last !== want.last) begin
            $display("%0t: result mismatch: expected status=%0d value=%h last=%b,",
                     $time, want.status, want.value, want.last);
            $display("%0t:   got status=%0d value=%h last=%b",
                     $time, got.status, got.value, got.last);
            fails++;
          end
        end
      end
      if (cfg_we) str_cap = cfg_wdata;
      if (in_chan.valid && in_chan.ready) begin
        rq.kind = in_chan.kind;
        rq.byte_value = in_chan.byte_value;
        rq.buffer_length = in_chan.buffer_length;
        rq.search_type = in_chan.search_type;
        rq.value_mode = in_chan.value_mode;
        scan_request(rq);
      end
    end
    fail_count <= fails;
    open_count <= awaited_results.size();
    result_count <= results;
  end

endmodule

>>> sim/tb.sv
// Testbench top for the TLV record lookup block: clock, reset, request and result traffic,
// capacity writes and the final verdict. Depends on tlvrl_pkg, both channel interfaces,
// tlv_record_lookup_core and tlvrl_lookup_checker.
module tb;
  import tlvrl_pkg::*;

  localparam int PHASE_ITEMS = 85;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  int               fail_count;
  int               open_count;
  int               result_count;

  int               max_gap_in;
  int               max_gap_out;
  int               hold_seq;
  int               items_sent;
  int               cur_cap;
  int               caps_used;
  logic [7:0]       tlv_bytes[$];

  tlvrl_in_if  in_chan();
  tlvrl_out_if out_chan();

  tlv_record_lookup_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tlvrl_lookup_checker lookup_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .out_chan     (out_chan),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .open_count   (open_count),
    .result_count (result_count)
  );

  always #6 clk = ~clk;

  initial begin
    #12_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // The result side stalls at random; a change of hold_seq asks for one long hold-off.
  initial begin
    int stall;
    int seen_hold;
    out_chan.ready = 1'b0;
    seen_hold = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = (hold_seq != seen_hold) ? 300 : $urandom_range(max_gap_out);
      seen_hold = hold_seq;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  task automatic send(input req_t rq);
    int gap;
    gap = $urandom_range(max_gap_in);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind <= rq.kind;
    in_chan.byte_value <= rq.byte_value;
    in_chan.buffer_length <= rq.buffer_length;
    in_chan.search_type <= rq.search_type;
    in_chan.value_mode <= rq.value_mode;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  // Fields that a request of the other kind carries are filled with noise.
  task automatic send_byte(input logic [7:0] b);
    req_t rq;
    rq.kind = 1'b1;
    rq.byte_value = b;
    rq.buffer_length = LEN_W'($urandom);
    rq.search_type = 8'($urandom);
    rq.value_mode = 1'($urandom);
    send(rq);
  endtask

  task automatic run_search(input int blen, input logic [7:0] ty, input logic mode);
    req_t rq;
    rq.kind = 1'b0;
    rq.byte_value = 8'($urandom);
    rq.buffer_length = LEN_W'(blen);
    rq.search_type = ty;
    rq.value_mode = mode;
    send(rq);
    foreach (tlv_bytes[i]) send_byte(tlv_bytes[i]);
    tlv_bytes.delete();
  endtask

  function automatic void put_header(input logic [7:0] ty, input logic [15:0] len);
    tlv_bytes.push_back(ty);
    tlv_bytes.push_back(len[15:8]);
    tlv_bytes.push_back(len[7:0]);
  endfunction

  function automatic void put_record(input logic [7:0] ty, input int len);
    put_header(ty, 16'(len));
    repeat (len) tlv_bytes.push_back(8'($urandom));
  endfunction

  function automatic int string_len_pick();
    int r;
    r = $urandom_range(9);
    if (cur_cap <= 40 && r == 0) return cur_cap;
    if (cur_cap <= 40 && cur_cap > 0 && r == 1) return cur_cap - 1;
    return $urandom_range(10);
  endfunction

  // Mostly well-formed buffers with one possible match; some have a wrong length,
  // trailing bytes after the search ends, or are cut short so the next start restarts.
  task automatic random_search();
    int         n;
    int         hit;
    int         pick;
    int         blen;
    int         d;
    logic [7:0] ty;
    logic [7:0] other;
    logic       mode;
    ty = 8'($urandom);
    mode = 1'($urandom);
    n = $urandom_range(4, 1);
    hit = $urandom_range(n);
    for (int i = 0; i < n; i++) begin
      if (i == hit) begin
        if (mode) put_record(ty, string_len_pick());
        else put_record(ty, ($urandom_range(9) == 0) ? $urandom_range(8) : 4);
      end else begin
        other = 8'($urandom);
        if (other == ty) other = other + 8'd1;
        put_record(other, $urandom_range(6));
      end
    end
    blen = tlv_bytes.size();
    pick = $urandom_range(9);
    case (pick)
      0: begin
        d = $urandom_range(3);
        blen = (blen > d) ? blen - d : 0;
      end
      1: blen = blen + $urandom_range(3);
      2: blen = $urandom_range(8191);
      3: repeat ($urandom_range(3, 1)) tlv_bytes.push_back(8'($urandom));
      4: repeat ($urandom_range(tlv_bytes.size())) void'(tlv_bytes.pop_back());
      default: ;
    endcase
    run_search(blen, ty, mode);
  endtask

  task automatic random_phase();
    int target;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(9) == 0) repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
      else random_search();
    end
  endtask

  task automatic pause_for_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (4) @(posedge clk);
  endtask

  // An empty buffer closes any open search so that the write lands while idle.
  task automatic set_capacity(input int c);
    run_search(0, 8'($urandom), 1'($urandom));
    pause_for_results();
    cfg_we <= 1'b1;
    cfg_wdata <= CAP_W'(c);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cap = c;
    caps_used++;
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.kind = 1'b0;
    in_chan.byte_value = '0;
    in_chan.buffer_length = '0;
    in_chan.search_type = '0;
    in_chan.value_mode = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    max_gap_in = 12;
    max_gap_out = 12;
    hold_seq = 0;
    items_sent = 0;
    cur_cap = 256;
    caps_used = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'hC3);
    run_search(0, 8'h00, 1'b0);
    run_search(2, 8'hFF, 1'b1);
    tlv_bytes = '{8'hA5, 8'h00, 8'h04, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
    run_search(7, 8'hA5, 1'b0);
    put_header(8'hFF, 16'h0000);
    run_search(3, 8'hFF, 1'b1);
    put_header(8'h01, 16'h0000);
    run_search(3, 8'h01, 1'b0);
    put_header(8'h02, 16'hFFFF);
    run_search(4, 8'h02, 1'b0);
    tlv_bytes = '{8'h10, 8'h00, 8'h01, 8'h99, 8'h33, 8'h00, 8'h02, 8'h41, 8'h42};
    run_search(9, 8'h33, 1'b1);

    set_capacity(0);
    random_phase();

    set_capacity(1);
    max_gap_in = 0;
    max_gap_out = 0;
    random_phase();

    set_capacity(5);
    max_gap_in = 12;
    random_phase();

    set_capacity(65536);
    max_gap_in = 0;
    max_gap_out = 12;
    hold_seq++;
    put_record(8'h5A, 40);
    run_search(43, 8'h5A, 1'b1);
    pause_for_results();
    max_gap_out = 0;
    put_header(8'h11, 16'd4094);
    run_search(8191, 8'h22, 1'b0);
    max_gap_out = 12;
    random_phase();

    set_capacity(256);
    max_gap_in = 12;
    put_header(8'h77, 16'd255);
    tlv_bytes.push_back(8'h61);
    run_search(258, 8'h77, 1'b1);
    put_header(8'h77, 16'd256);
    run_search(259, 8'h77, 1'b1);
    random_phase();

    set_capacity(65535);
    max_gap_in = 6;
    max_gap_out = 6;
    random_phase();

    set_capacity($urandom_range(40, 2));
    max_gap_in = 12;
    max_gap_out = 12;
    random_phase();

    pause_for_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests under %0d capacity settings and checked %0d results.",
             items_sent, caps_used + 1, result_count);
    $display("Searches covered word and string matches, misses, truncation, overruns, %s",
             "bad lengths, restarts, a long result stall and buffer length saturation.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
